FILE: rtl/b32_pkg.sv
// Shared types, constants and character helpers of the base32 stream codec.
// Used by every module of the codec; depends on nothing else.
`default_nettype none

package b32_pkg;

  localparam int DATA_WIDTH          = 8;
  localparam int LIMIT_WIDTH         = 10;
  localparam int PCOUNT_WIDTH        = 10;
  localparam int CFG_INDEX_WIDTH     = 4;
  localparam int COUNT_WIDTH_DEFAULT = 10;
  localparam int QUEUE_DEPTH_DEFAULT = 4;
  localparam int BITS_WIDTH          = 12;
  localparam int CNT_WIDTH           = 4;
  localparam int OUT_TDATA_WIDTH     = 24;

  localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = 10'd192;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_MODE         = 4'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_OUTPUT_LIMIT = 4'd1;

  // Stream status codes.
  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_BAD   = 2'd1;
  localparam logic [1:0] ERR_LIMIT = 2'd2;

  localparam logic [7:0] CHAR_PAD     = 8'h3D;  // '='
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_TWO     = 8'h32;
  localparam logic [7:0] CHAR_SEVEN   = 8'h37;
  localparam logic [4:0] ALPHA_COUNT  = 5'd26;

  typedef enum logic [1:0] {
    K_BYTE,  // raw byte to encode
    K_CHAR,  // valid base32 character, 5-bit value in data
    K_SKIP,  // padding character
    K_BAD    // character outside the alphabet
  } kind_t;

  typedef struct packed {
    kind_t                 kind;
    logic [DATA_WIDTH-1:0] data;
    logic                  last;
  } item_t;

  // Character of a 5-bit group in the lowercase alphabet.
  function automatic logic [7:0] sym_char(input logic [4:0] idx);
    logic [7:0] wide;
    wide = {3'b000, idx};
    if (idx < ALPHA_COUNT) begin
      return CHAR_LOWER_A + wide;
    end
    return CHAR_TWO + wide - {3'b000, ALPHA_COUNT};
  endfunction

  // Returns {ok, value} for a character; ok is 0 outside the alphabet.
  function automatic logic [5:0] char_value(input logic [7:0] c);
    logic [7:0] diff;
    diff = 8'd0;
    if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
      diff = c - CHAR_LOWER_A;
      return {1'b1, diff[4:0]};
    end
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      diff = c - CHAR_UPPER_A;
      return {1'b1, diff[4:0]};
    end
    if (c >= CHAR_TWO && c <= CHAR_SEVEN) begin
      diff = c - CHAR_TWO + {3'b000, ALPHA_COUNT};
      return {1'b1, diff[4:0]};
    end
    return 6'd0;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/base32_stream_codec.sv
// Base32 stream codec (lowercase alphabet, no padding), encode or decode by mode.
// An accepted word waits in the queue; the back end then registers its first result.
// Throughput: one result word per cycle into the output register while it is not stalled;
// an input word is held at the head of the queue until its last symbol has been emitted.
// Reset (rst, synchronous): mode encode, output limit 192, queue empty, stream state clear.
`default_nettype none

module base32_stream_codec #(
  parameter int COUNT_WIDTH = b32_pkg::COUNT_WIDTH_DEFAULT,
  parameter int QUEUE_DEPTH = b32_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [b32_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
  input  wire logic [b32_pkg::LIMIT_WIDTH-1:0]       cfg_data,
  input  wire logic                                  s_axis_tvalid,
  output logic                                       s_axis_tready,
  input  wire logic [b32_pkg::DATA_WIDTH-1:0]        s_axis_tdata,   // [7:0] data_in
  input  wire logic                                  s_axis_tlast,   // last
  output logic                                       m_axis_tvalid,
  input  wire logic                                  m_axis_tready,
  // [7:0] data_out, [9:8] status, [19:10] produced_count, [23:20] zero
  output logic [b32_pkg::OUT_TDATA_WIDTH-1:0]        m_axis_tdata,
  output logic                                       m_axis_tlast,   // end_of_stream
  output logic                                       m_axis_tuser    // [0] data_valid
);

  logic                                q_push, q_ready, q_valid, q_pop, clr;
  logic [b32_pkg::LIMIT_WIDTH-1:0]     limit;
  b32_pkg::item_t                      wr_item, rd_item;

  b32_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .q_push        (q_push),
    .q_ready       (q_ready),
    .q_item        (wr_item),
    .clr           (clr),
    .limit         (limit)
  );

  b32_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .ready   (q_ready),
    .wr_item (wr_item),
    .valid   (q_valid),
    .pop     (q_pop),
    .rd_item (rd_item)
  );

  b32_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .clr           (clr),
    .limit         (limit),
    .q_valid       (q_valid),
    .q_item        (rd_item),
    .q_pop         (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

`default_nettype wire

FILE: rtl/b32_front.sv
// Front end of the base32 codec: configuration registers and input classification.
// Depends on b32_pkg.
`default_nettype none

module b32_front (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    cfg_valid,
  output logic                                         cfg_ready,
  input  wire logic [b32_pkg::CFG_INDEX_WIDTH-1:0]     cfg_index,
  input  wire logic [b32_pkg::LIMIT_WIDTH-1:0]         cfg_data,
  input  wire logic                                    s_axis_tvalid,
  output logic                                         s_axis_tready,
  input  wire logic [b32_pkg::DATA_WIDTH-1:0]          s_axis_tdata,
  input  wire logic                                    s_axis_tlast,
  output logic                                         q_push,
  input  wire logic                                    q_ready,
  output b32_pkg::item_t                               q_item,
  output logic                                         clr,
  output logic [b32_pkg::LIMIT_WIDTH-1:0]              limit
);

  logic       mode;
  logic [5:0] cv;

  assign cfg_ready     = 1'b1;
  assign clr           = cfg_valid && (cfg_index == b32_pkg::REG_MODE);
  assign s_axis_tready = q_ready;
  assign q_push        = s_axis_tvalid && q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= 1'b0;
      limit <= b32_pkg::LIMIT_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == b32_pkg::REG_MODE) begin
        mode <= cfg_data[0];
      end else if (cfg_index == b32_pkg::REG_OUTPUT_LIMIT) begin
        limit <= cfg_data;
      end
    end
  end

  always_comb begin
    cv          = b32_pkg::char_value(s_axis_tdata);
    q_item.last = s_axis_tlast;
    q_item.data = s_axis_tdata;
    q_item.kind = b32_pkg::K_BYTE;
    if (mode) begin
      if (s_axis_tdata == b32_pkg::CHAR_PAD) begin
        q_item.kind = b32_pkg::K_SKIP;
      end else if (cv[5]) begin
        q_item.kind = b32_pkg::K_CHAR;
        q_item.data = {3'b000, cv[4:0]};
      end else begin
        q_item.kind = b32_pkg::K_BAD;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/b32_queue.sv
// Small word queue between the front end and the back end of the base32 codec.
// Depends on b32_pkg for the queued word type.
`default_nettype none

module b32_queue #(
  parameter int DEPTH = b32_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  output logic                ready,
  input  wire b32_pkg::item_t wr_item,
  output logic                valid,
  input  wire logic           pop,
  output b32_pkg::item_t      rd_item
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL     = CW'(DEPTH);

  b32_pkg::item_t  mem [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign ready   = count != FULL;
  assign valid   = count != '0;
  assign rd_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_item;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/b32_back.sv
// Back end of the base32 codec: bit buffer, symbol emission, limit and status.
// Emits one result word per cycle into the output register when not stalled. Depends on b32_pkg.
`default_nettype none

module b32_back #(
  parameter int COUNT_WIDTH = b32_pkg::COUNT_WIDTH_DEFAULT
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 clr,
  input  wire logic [b32_pkg::LIMIT_WIDTH-1:0]      limit,
  input  wire logic                                 q_valid,
  input  wire b32_pkg::item_t                       q_item,
  output logic                                      q_pop,
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  output logic [b32_pkg::OUT_TDATA_WIDTH-1:0]       m_axis_tdata,
  output logic                                      m_axis_tlast,
  output logic                                      m_axis_tuser
);

  localparam int CMPW = (COUNT_WIDTH > b32_pkg::LIMIT_WIDTH) ?
                        COUNT_WIDTH : b32_pkg::LIMIT_WIDTH;
  localparam int BW = b32_pkg::BITS_WIDTH;
  localparam int NW = b32_pkg::CNT_WIDTH;

  logic [BW-1:0]          bit_buf;
  logic [NW-1:0]          bit_cnt;
  logic [COUNT_WIDTH-1:0] emitted;
  logic [1:0]             err;
  logic                   started;

  logic [BW-1:0]          ins_bits, eff_bits;
  logic [NW-1:0]          ins_cnt, eff_cnt, cnt_n;
  logic [1:0]             ins_err, eff_err, err_after;
  logic                   enc, wanted, emit, more2, next_ok, done, finish, produce;
  logic                   out_free, step;
  logic [COUNT_WIDTH-1:0] emitted_n, emitted_after;
  logic [CMPW-1:0]        ext_limit, ext_after;
  logic [BW+4:0]          enc_sel;
  logic [BW-1:0]          dec_sel;
  logic [7:0]             sym;

  always_comb begin
    enc      = q_item.kind == b32_pkg::K_BYTE;
    ins_bits = bit_buf;
    ins_cnt  = bit_cnt;
    ins_err  = err;
    if (q_valid && err == b32_pkg::ERR_NONE) begin
      unique case (q_item.kind)
        b32_pkg::K_BYTE: begin
          ins_bits = {bit_buf[BW-9:0], q_item.data};
          ins_cnt  = bit_cnt + 4'd8;
        end
        b32_pkg::K_CHAR: begin
          ins_bits = {bit_buf[BW-6:0], q_item.data[4:0]};
          ins_cnt  = bit_cnt + 4'd5;
        end
        b32_pkg::K_BAD:  ins_err = b32_pkg::ERR_BAD;
        b32_pkg::K_SKIP: ins_err = err;
      endcase
    end

    // The first step of a word takes its bits in; later steps work on the buffer.
    eff_bits = started ? bit_buf : ins_bits;
    eff_cnt  = started ? bit_cnt : ins_cnt;
    eff_err  = started ? err     : ins_err;

    wanted = (eff_err == b32_pkg::ERR_NONE) &&
             (enc ? (eff_cnt >= 4'd5 || (q_item.last && eff_cnt != 4'd0))
                  : (eff_cnt >= 4'd8));

    ext_limit = CMPW'(limit);
    emit      = wanted && (CMPW'(emitted) < ext_limit) && (emitted != '1);
    emitted_n = emitted + COUNT_WIDTH'(1);

    // Encode picks the group just above the zero-filled tail; this also covers the flush.
    enc_sel = {eff_bits, 5'b00000} >> eff_cnt;
    dec_sel = eff_bits >> (eff_cnt - 4'd8);
    sym     = enc ? b32_pkg::sym_char(enc_sel[4:0]) : dec_sel[7:0];

    if (enc) begin
      cnt_n = (eff_cnt >= 4'd5) ? eff_cnt - 4'd5 : 4'd0;
    end else begin
      cnt_n = eff_cnt - 4'd8;
    end
    more2 = enc ? (cnt_n >= 4'd5 || (q_item.last && cnt_n != 4'd0))
                : (cnt_n >= 4'd8);
    next_ok = more2 && (CMPW'(emitted_n) < ext_limit) && (emitted_n != '1);

    // A symbol is final for its word when no further symbol can follow it.
    done = !emit || !next_ok;
    if (emit) begin
      err_after = (more2 && !next_ok) ? b32_pkg::ERR_LIMIT : eff_err;
    end else begin
      err_after = wanted ? b32_pkg::ERR_LIMIT : eff_err;
    end
    emitted_after = emit ? emitted_n : emitted;
    ext_after     = CMPW'(emitted_after);
    finish        = done && q_item.last;
    produce       = emit || finish;

    out_free = !m_axis_tvalid || m_axis_tready;
    step     = q_valid && out_free;
    q_pop    = step && done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      started       <= 1'b0;
      bit_buf       <= '0;
      bit_cnt       <= '0;
      emitted       <= '0;
      err           <= b32_pkg::ERR_NONE;
    end else begin
      if (step && produce) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (clr) begin
        started <= 1'b0;
        bit_buf <= '0;
        bit_cnt <= '0;
        emitted <= '0;
        err     <= b32_pkg::ERR_NONE;
      end else if (step) begin
        if (finish) begin
          started <= 1'b0;
          bit_buf <= '0;
          bit_cnt <= '0;
          emitted <= '0;
          err     <= b32_pkg::ERR_NONE;
        end else begin
          started <= !done;
          bit_buf <= eff_bits;
          bit_cnt <= emit ? cnt_n : eff_cnt;
          emitted <= emitted_after;
          err     <= err_after;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step && produce) begin
      m_axis_tdata <= {4'b0000,
                       finish ? ext_after[b32_pkg::PCOUNT_WIDTH-1:0]
                              : {b32_pkg::PCOUNT_WIDTH{1'b0}},
                       finish ? err_after : b32_pkg::ERR_NONE,
                       emit ? sym : 8'd0};
      m_axis_tlast <= finish;
      m_axis_tuser <= emit;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/b32_checker.sv
// Port-level checks of the base32 stream codec, bound to its top level.
// Depends on b32_pkg and base32_stream_codec.
`default_nettype none

module b32_checker (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                m_axis_tvalid,
  input wire logic                                m_axis_tready,
  input wire logic [b32_pkg::OUT_TDATA_WIDTH-1:0] m_axis_tdata,
  input wire logic                                m_axis_tlast,
  input wire logic                                m_axis_tuser
);

  // A stalled result word holds its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) &&
      $stable(m_axis_tuser))
    else $error("result word changed while stalled");

  // A word without a symbol only ever closes a stream.
  a_status_only_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast && m_axis_tdata[7:0] == 8'd0)
    else $error("status-only word that does not end the stream");

  // Status and count are zero on every word before the end of the stream.
  a_mid_stream_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[19:8] == 12'd0)
    else $error("status or count set on a word inside the stream");

  // Only the three defined status codes appear.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[9:8] != 2'd3)
    else $error("undefined status code");

endmodule

bind base32_stream_codec b32_checker u_b32_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for base32_stream_codec: directed streams, then random streams.
// A scoreboard class predicts every result word; depends on rtl/b32_pkg.sv and the codec RTL.

module tb;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;
  localparam string ALPHABET = "abcdefghijklmnopqrstuvwxyz234567";
  localparam logic [7:0] CASE_BIT = 8'h20;
  localparam logic [b32_pkg::PCOUNT_WIDTH-1:0] COUNT_CEILING = '1;
  localparam logic [b32_pkg::LIMIT_WIDTH-1:0] LIMIT_MAX = '1;
  localparam logic [b32_pkg::CFG_INDEX_WIDTH-1:0] REG_UNUSED_LO =
    b32_pkg::REG_OUTPUT_LIMIT + 4'd1;
  localparam logic [b32_pkg::CFG_INDEX_WIDTH-1:0] REG_UNUSED_HI = '1;
  localparam int SETTLE_CYCLES = 24;
  localparam int CYCLE_LIMIT = 200000;
  localparam int ITEMS_PER_PHASE = 4;
  localparam int SEND_IDLE[4] = '{0, 54, 0, 9};
  localparam int RECV_STALL[4] = '{0, 0, 54, 9};
  localparam logic [b32_pkg::LIMIT_WIDTH-1:0] PHASE_LIMIT[8] =
    '{10'd1023, 10'd4, 10'd192, 10'd1, 10'd1023, 10'd7, 10'd40, 10'd2};

  typedef struct packed {
    logic [7:0]                       data;
    logic                             data_valid;
    logic                             eos;
    logic [1:0]                       status;
    logic [b32_pkg::PCOUNT_WIDTH-1:0] count;
  } codec_word_t;

  class b32_scoreboard;
    logic                             mode;
    logic [b32_pkg::LIMIT_WIDTH-1:0]  limit;
    logic [b32_pkg::BITS_WIDTH-1:0]   pending_bits;
    logic [b32_pkg::CNT_WIDTH-1:0]    pending_count;
    logic [b32_pkg::PCOUNT_WIDTH-1:0] emitted;
    logic [1:0]                       stream_error;
    codec_word_t                      step_words[$];
    codec_word_t                      expected_words[$];
    int                               errors;

    function new();
      mode = MODE_ENCODE;
      limit = b32_pkg::LIMIT_RESET;
      errors = 0;
      clear_stream();
    endfunction

    function void clear_stream();
      pending_bits = '0;
      pending_count = '0;
      emitted = '0;
      stream_error = b32_pkg::ERR_NONE;
    endfunction

    function void write_reg(logic [b32_pkg::CFG_INDEX_WIDTH-1:0] idx,
                            logic [b32_pkg::LIMIT_WIDTH-1:0] val);
      if (idx == b32_pkg::REG_MODE) begin
        mode = val[0];
        clear_stream();
      end else if (idx == b32_pkg::REG_OUTPUT_LIMIT) begin
        limit = val;
      end
    endfunction

    // Once the stream holds an error, nothing more leaves until its end.
    function void put_symbol(logic [7:0] sym);
      if (stream_error != b32_pkg::ERR_NONE) return;
      if (emitted >= limit || emitted >= COUNT_CEILING) begin
        stream_error = b32_pkg::ERR_LIMIT;
        return;
      end
      emitted = emitted + 1'b1;
      step_words.push_back('{sym, 1'b1, 1'b0, b32_pkg::ERR_NONE, '0});
    endfunction

    function void predict_codec_output(logic [7:0] d, logic last);
      logic [b32_pkg::BITS_WIDTH-1:0] shifted;
      logic [7:0]                     c;
      logic [4:0]                     value;
      logic                           ok;
      codec_word_t                    tail;
      step_words.delete();
      if (stream_error == b32_pkg::ERR_NONE) begin
        if (mode == MODE_ENCODE) begin
          pending_bits = {pending_bits[3:0], d};
          pending_count = pending_count + 4'd8;
          while (pending_count >= 4'd5 && stream_error == b32_pkg::ERR_NONE) begin
            pending_count = pending_count - 4'd5;
            shifted = pending_bits >> pending_count;
            put_symbol(ALPHABET[shifted[4:0]]);
          end
          if (last && pending_count > 0 && pending_count < 4'd5 &&
              stream_error == b32_pkg::ERR_NONE) begin
            shifted = pending_bits << (4'd5 - pending_count);
            put_symbol(ALPHABET[shifted[4:0]]);
          end
        end else if (d != b32_pkg::CHAR_PAD) begin
          ok = 1'b1;
          value = '0;
          c = d | CASE_BIT;
          if (d >= b32_pkg::CHAR_UPPER_A && d <= b32_pkg::CHAR_UPPER_Z ||
              d >= b32_pkg::CHAR_LOWER_A && d <= b32_pkg::CHAR_LOWER_Z)
            value = 5'(c - b32_pkg::CHAR_LOWER_A);
          else if (d >= b32_pkg::CHAR_TWO && d <= b32_pkg::CHAR_SEVEN)
            value = 5'(d - b32_pkg::CHAR_TWO) + b32_pkg::ALPHA_COUNT;
          else
            ok = 1'b0;
          if (!ok) begin
            stream_error = b32_pkg::ERR_BAD;
          end else begin
            pending_bits = {pending_bits[6:0], value};
            pending_count = pending_count + 4'd5;
            if (pending_count >= 4'd8) begin
              pending_count = pending_count - 4'd8;
              shifted = pending_bits >> pending_count;
              put_symbol(shifted[7:0]);
            end
          end
        end
      end
      if (last) begin
        // A final byte or character that leaves no symbol still gets a status word.
        if (step_words.size() == 0)
          step_words.push_back('{8'h00, 1'b0, 1'b0, b32_pkg::ERR_NONE, '0});
        tail = step_words.pop_back();
        tail.eos = 1'b1;
        tail.status = stream_error;
        tail.count = emitted;
        step_words.push_back(tail);
        clear_stream();
      end
      foreach (step_words[i]) expected_words.push_back(step_words[i]);
    endfunction

    function void compare_field(string field, int want, int got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_codec_output(logic [b32_pkg::OUT_TDATA_WIDTH-1:0] tdata,
                                     logic tlast, logic tuser);
      codec_word_t want;
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual tdata 0x%0h last %0b",
                 $time, tdata, tlast);
        errors++;
        return;
      end
      want = expected_words.pop_front();
      compare_field("data_out", want.data, tdata[7:0]);
      compare_field("data_valid", want.data_valid, tuser);
      compare_field("end_of_stream", want.eos, tlast);
      compare_field("status", want.status, tdata[9:8]);
      compare_field("produced_count", want.count, tdata[19:10]);
    endfunction
  endclass

  logic                                   clk;
  logic                                   rst;
  logic                                   cfg_valid;
  logic                                   cfg_ready;
  logic [b32_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index;
  logic [b32_pkg::LIMIT_WIDTH-1:0]        cfg_data;
  logic                                   s_axis_tvalid;
  logic                                   s_axis_tready;
  logic [b32_pkg::DATA_WIDTH-1:0]         s_axis_tdata;
  logic                                   s_axis_tlast;
  logic                                   m_axis_tvalid;
  logic                                   m_axis_tready;
  logic [b32_pkg::OUT_TDATA_WIDTH-1:0]    m_axis_tdata;
  logic                                   m_axis_tlast;
  logic                                   m_axis_tuser;

  b32_scoreboard sb;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int cycles = 0;

  base32_stream_codec dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast), .m_axis_tuser(m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Receiver: checks at the rising edge, decides the next stall at the falling edge.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready)
        sb.check_codec_output(m_axis_tdata, m_axis_tlast, m_axis_tuser);
      @(negedge clk);
      m_axis_tready = ($urandom_range(99, 0) >= stall_pct);
    end
  end

  // All driving tasks start and end right after a falling edge.
  task automatic send_word(input logic [7:0] d, input logic l);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = d;
    s_axis_tlast = l;
    do @(posedge clk); while (!s_axis_tready);
    sb.predict_codec_output(d, l);
    @(negedge clk);
  endtask

  // Words that produce nothing may still be in flight, so wait a little past the last result.
  task automatic drain(input int settle);
    s_axis_tvalid = 1'b0;
    while (sb.expected_words.size() != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  task automatic write_reg(input logic [b32_pkg::CFG_INDEX_WIDTH-1:0] idx,
                           input logic [b32_pkg::LIMIT_WIDTH-1:0] val);
    drain(SETTLE_CYCLES);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Only bit 0 selects the mode; the upper bits are random.
  task automatic set_mode(input logic m);
    logic [b32_pkg::LIMIT_WIDTH-1:0] val;
    val = b32_pkg::LIMIT_WIDTH'($urandom_range(1023, 0));
    val[0] = m;
    write_reg(b32_pkg::REG_MODE, val);
  endtask

  // Decode input is mostly alphabet characters of either case, with some padding and noise.
  function automatic logic [7:0] random_input(input logic m);
    int roll;
    logic [7:0] c;
    if (m == MODE_ENCODE) return 8'($urandom_range(255, 0));
    roll = $urandom_range(99, 0);
    if (roll < 90) begin
      c = ALPHABET[$urandom_range(31, 0)];
      if (c >= b32_pkg::CHAR_LOWER_A && $urandom_range(1, 0) == 1) c = c & ~CASE_BIT;
      return c;
    end
    if (roll < 95) return b32_pkg::CHAR_PAD;
    return 8'($urandom_range(255, 0));
  endfunction

  task automatic send_stream(input int len, input logic m, input logic ends);
    for (int i = 0; i < len; i++)
      send_word(random_input(m), ends && i == len - 1);
  endtask

  initial begin
    int sent;
    int len;
    bit paused;
    logic m;
    sb = new();
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    repeat (5) @(negedge clk);
    rst = 1'b0;

    // Encode at the reset limit: lone bytes flush their leftover bits, five bytes flush none.
    send_word(8'h00, 1'b1);
    send_word(8'hFF, 1'b1);
    send_word(8'h12, 1'b0);
    send_word(8'h34, 1'b0);
    send_word(8'h56, 1'b0);
    send_word(8'h78, 1'b0);
    send_word(8'h9A, 1'b1);
    // A zero limit rejects the first symbol; a limit of one rejects the second.
    write_reg(b32_pkg::REG_OUTPUT_LIMIT, '0);
    send_word(8'hA5, 1'b1);
    write_reg(b32_pkg::REG_OUTPUT_LIMIT, 10'd1);
    send_word(8'hAB, 1'b0);
    send_word(8'hCD, 1'b1);
    write_reg(REG_UNUSED_HI, LIMIT_MAX);
    write_reg(b32_pkg::REG_OUTPUT_LIMIT, LIMIT_MAX);
    // Leave a stream open; the mode change must drop it.
    send_word(8'h55, 1'b0);
    set_mode(MODE_DECODE);
    // Both cases and digits; padding last gives a status word; four leftover bits dropped.
    send_word(b32_pkg::CHAR_LOWER_A, 1'b0);
    send_word(b32_pkg::CHAR_UPPER_Z, 1'b0);
    send_word(b32_pkg::CHAR_TWO, 1'b0);
    send_word(b32_pkg::CHAR_SEVEN, 1'b0);
    send_word(b32_pkg::CHAR_PAD, 1'b1);
    // A bad character is sticky for the rest of the stream.
    send_word(b32_pkg::CHAR_UPPER_A + 8'd1, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b1);
    // Lowering the limit mid-stream keeps the count already emitted.
    send_word(b32_pkg::CHAR_SEVEN, 1'b0);
    send_word(b32_pkg::CHAR_SEVEN, 1'b0);
    write_reg(b32_pkg::REG_OUTPUT_LIMIT, 10'd1);
    send_word(b32_pkg::CHAR_SEVEN, 1'b0);
    send_word(b32_pkg::CHAR_SEVEN, 1'b1);

    for (int p = 0; p < 8; p++) begin
      m = (p % 2 == 1) ? MODE_DECODE : MODE_ENCODE;
      set_mode(m);
      write_reg(b32_pkg::REG_OUTPUT_LIMIT, PHASE_LIMIT[p]);
      if (p == 3)
        write_reg(b32_pkg::CFG_INDEX_WIDTH'($urandom_range(REG_UNUSED_HI, REG_UNUSED_LO)),
                  b32_pkg::LIMIT_WIDTH'($urandom_range(1023, 0)));
      send_idle_pct = SEND_IDLE[p % 4];
      stall_pct = RECV_STALL[p % 4];
      sent = 0;
      paused = 1'b0;
      while (sent < ITEMS_PER_PHASE) begin
        len = ($urandom_range(99, 0) < 80) ? $urandom_range(8, 1) : $urandom_range(30, 9);
        send_stream(len, m, 1'b1);
        sent += len;
        if (!paused && sent >= ITEMS_PER_PHASE / 2) begin
          drain(0);
          paused = 1'b1;
        end
      end
      // Sometimes leave a stream open for the next mode write to abort.
      if ($urandom_range(1, 0) == 1) send_stream($urandom_range(3, 1), m, 1'b0);
    end

    drain(SETTLE_CYCLES);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
